>>> src/sfcr_pkg.sv
// Shared types, constants and the CRC16 lookup table of the sample frame reader.
`default_nettype none

package sfcr_pkg;

  // Operation codes carried by the input word.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COMMAND = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  BAD_POINTER  = 8'hFF;
  // Command that selects the CRC bytes, and the offset it points at.
  localparam logic [7:0]  CMD_CRC_SLOT = 8'd9;
  localparam logic [7:0]  CRC_PTR      = 8'd8;
  // Highest command that selects a sample slot.
  localparam logic [7:0]  CMD_LAST_SAMPLE = 8'd3;

  // Control of the CRC accumulator.
  typedef struct packed {
    logic init;
    logic step;
  } crc_ctl_t;

  localparam logic [15:0] CRC_LUT [256] = '{
    16'h0000, 16'ha001, 16'he003, 16'h4002, 16'h6007, 16'hc006, 16'h8004, 16'h2005,
    16'hc00e, 16'h600f, 16'h200d, 16'h800c, 16'ha009, 16'h0008, 16'h400a, 16'he00b,
    16'h201d, 16'h801c, 16'hc01e, 16'h601f, 16'h401a, 16'he01b, 16'ha019, 16'h0018,
    16'he013, 16'h4012, 16'h0010, 16'ha011, 16'h8014, 16'h2015, 16'h6017, 16'hc016,
    16'h403a, 16'he03b, 16'ha039, 16'h0038, 16'h203d, 16'h803c, 16'hc03e, 16'h603f,
    16'h8034, 16'h2035, 16'h6037, 16'hc036, 16'he033, 16'h4032, 16'h0030, 16'ha031,
    16'h6027, 16'hc026, 16'h8024, 16'h2025, 16'h0020, 16'ha021, 16'he023, 16'h4022,
    16'ha029, 16'h0028, 16'h402a, 16'he02b, 16'hc02e, 16'h602f, 16'h202d, 16'h802c,
    16'h8074, 16'h2075, 16'h6077, 16'hc076, 16'he073, 16'h4072, 16'h0070, 16'ha071,
    16'h407a, 16'he07b, 16'ha079, 16'h0078, 16'h207d, 16'h807c, 16'hc07e, 16'h607f,
    16'ha069, 16'h0068, 16'h406a, 16'he06b, 16'hc06e, 16'h606f, 16'h206d, 16'h806c,
    16'h6067, 16'hc066, 16'h8064, 16'h2065, 16'h0060, 16'ha061, 16'he063, 16'h4062,
    16'hc04e, 16'h604f, 16'h204d, 16'h804c, 16'ha049, 16'h0048, 16'h404a, 16'he04b,
    16'h0040, 16'ha041, 16'he043, 16'h4042, 16'h6047, 16'hc046, 16'h8044, 16'h2045,
    16'he053, 16'h4052, 16'h0050, 16'ha051, 16'h8054, 16'h2055, 16'h6057, 16'hc056,
    16'h205d, 16'h805c, 16'hc05e, 16'h605f, 16'h405a, 16'he05b, 16'ha059, 16'h0058,
    16'ha0e9, 16'h00e8, 16'h40ea, 16'he0eb, 16'hc0ee, 16'h60ef, 16'h20ed, 16'h80ec,
    16'h60e7, 16'hc0e6, 16'h80e4, 16'h20e5, 16'h00e0, 16'ha0e1, 16'he0e3, 16'h40e2,
    16'h80f4, 16'h20f5, 16'h60f7, 16'hc0f6, 16'he0f3, 16'h40f2, 16'h00f0, 16'ha0f1,
    16'h40fa, 16'he0fb, 16'ha0f9, 16'h00f8, 16'h20fd, 16'h80fc, 16'hc0fe, 16'h60ff,
    16'he0d3, 16'h40d2, 16'h00d0, 16'ha0d1, 16'h80d4, 16'h20d5, 16'h60d7, 16'hc0d6,
    16'h20dd, 16'h80dc, 16'hc0de, 16'h60df, 16'h40da, 16'he0db, 16'ha0d9, 16'h00d8,
    16'hc0ce, 16'h60cf, 16'h20cd, 16'h80cc, 16'ha0c9, 16'h00c8, 16'h40ca, 16'he0cb,
    16'h00c0, 16'ha0c1, 16'he0c3, 16'h40c2, 16'h60c7, 16'hc0c6, 16'h80c4, 16'h20c5,
    16'h209d, 16'h809c, 16'hc09e, 16'h609f, 16'h409a, 16'he09b, 16'ha099, 16'h0098,
    16'he093, 16'h4092, 16'h0090, 16'ha091, 16'h8094, 16'h2095, 16'h6097, 16'hc096,
    16'h0080, 16'ha081, 16'he083, 16'h4082, 16'h6087, 16'hc086, 16'h8084, 16'h2085,
    16'hc08e, 16'h608f, 16'h208d, 16'h808c, 16'ha089, 16'h0088, 16'h408a, 16'he08b,
    16'h60a7, 16'hc0a6, 16'h80a4, 16'h20a5, 16'h00a0, 16'ha0a1, 16'he0a3, 16'h40a2,
    16'ha0a9, 16'h00a8, 16'h40aa, 16'he0ab, 16'hc0ae, 16'h60af, 16'h20ad, 16'h80ac,
    16'h40ba, 16'he0bb, 16'ha0b9, 16'h00b8, 16'h20bd, 16'h80bc, 16'hc0be, 16'h60bf,
    16'h80b4, 16'h20b5, 16'h60b7, 16'hc0b6, 16'he0b3, 16'h40b2, 16'h00b0, 16'ha0b1
  };

endpackage

`default_nettype wire

>>> src/sfcr_if.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface sfcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] sample_value;
  logic [7:0]  command_byte;

  modport source (output valid, output op, output sample_value, output command_byte,
                  input ready);
  modport sink (input valid, input op, input sample_value, input command_byte,
                output ready);
endinterface

interface sfcr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic        out_of_range;
  logic        frame_done;
  logic [15:0] frame_crc;

  modport source (output valid, output read_byte, output out_of_range, output frame_done,
                  output frame_crc, input ready);
  modport sink (input valid, input read_byte, input out_of_range, input frame_done,
                input frame_crc, output ready);
endinterface

`default_nettype wire

>>> src/sfcr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module sfcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/sfcr_crc.sv
// Table-driven CRC16 accumulator that folds in one byte per step.
`default_nettype none

module sfcr_crc (
  input  wire logic              clk,
  input  wire sfcr_pkg::crc_ctl_t ctl,
  input  wire logic [7:0]        data,
  output logic      [15:0]       crc
);
  import sfcr_pkg::*;

  logic [7:0]  idx;
  logic [15:0] crc_next;

  // One table lookup per byte: index by the high byte mixed with the data.
  always_comb begin
    idx      = crc[15:8] ^ data;
    crc_next = {crc[7:0], 8'h00} ^ CRC_LUT[idx];
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.step) begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/sample_frame_crc_register_reader.sv
// Top level: sequencer around the frame store RAM, CRC unit and result register.
//
// Each input word is taken in the idle state and worked on alone. A command word
// goes to its result state directly; a read in range waits in a state for the
// registered RAM read; a sample writes its low and high byte into the store. The
// sample that completes a frame also runs the CRC over the 2*SAMPLES_PER_FRAME
// stored bytes, one RAM read and one table lookup per cycle, then writes the two
// CRC bytes. The frame store has a single write port and a single read port. The
// store clears at reset through one valid bit per byte, so no clearing pass is
// needed. A finished result waits in the output register while the next word is
// accepted.
`default_nettype none

module sample_frame_crc_register_reader #(
  parameter int SAMPLES_PER_FRAME = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  sfcr_in_if.sink   in_ch,
  sfcr_out_if.source out_ch
);
  import sfcr_pkg::*;

  localparam int DATA_BYTES  = 2 * SAMPLES_PER_FRAME;
  localparam int STORE_BYTES = DATA_BYTES + 2;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int SLOT_W      = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
  localparam int CNT_W       = $clog2(DATA_BYTES + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WLO    = 8'b0000_0010,
    S_WHI    = 8'b0000_0100,
    S_RDWAIT = 8'b0000_1000,
    S_CRC    = 8'b0001_0000,
    S_CLO    = 8'b0010_0000,
    S_CHI    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [SLOT_W-1:0]   slot;
  logic [7:0]          ptr;
  logic [CNT_W-1:0]    cnt;
  logic [15:0]         sample;
  logic [STORE_BYTES-1:0] vld;
  logic                rd_vld;

  // Result being built for the current word.
  logic [7:0]          res_byte;
  logic                res_oor;
  logic                res_done;
  logic [15:0]         res_crc;

  logic                accept;
  logic                emit;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_q;
  logic [7:0]          rd_byte;
  logic [ADDR_W-1:0]   slot_addr;
  logic                slot_last;
  logic                ptr_in_range;
  crc_ctl_t            crc_ctl;
  logic [15:0]         crc;

  assign in_ch.ready  = (state == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign emit         = (state == S_EMIT) && (!out_ch.valid || out_ch.ready);
  assign slot_addr    = ADDR_W'({slot, 1'b0});
  assign slot_last    = (slot == SLOT_W'(SAMPLES_PER_FRAME - 1));
  assign ptr_in_range = (ptr < 8'(STORE_BYTES));
  // Bytes never written since reset read as zero.
  assign rd_byte      = rd_vld ? ram_q : 8'h00;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_ch.op))
            OP_SAMPLE: state_next = S_WLO;
            OP_READ:   state_next = ptr_in_range ? S_RDWAIT : S_EMIT;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_WLO:    state_next = S_WHI;
      S_WHI:    state_next = slot_last ? S_CRC : S_EMIT;
      S_RDWAIT: state_next = S_EMIT;
      S_CRC:    state_next = (cnt == CNT_W'(DATA_BYTES)) ? S_CLO : S_CRC;
      S_CLO:    state_next = S_CHI;
      S_CHI:    state_next = S_EMIT;
      S_EMIT:   state_next = emit ? S_IDLE : S_EMIT;
      default:  state_next = S_IDLE;
    endcase
  end

  // Frame store write and read addressing.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    ram_wdata = sample[7:0];
    ram_raddr = '0;
    crc_ctl   = '0;
    case (state)
      S_IDLE: ram_raddr = ptr[ADDR_W-1:0];
      S_WLO:  ram_we = 1'b1;
      S_WHI: begin
        ram_we       = 1'b1;
        ram_waddr    = slot_addr + ADDR_W'(1);
        ram_wdata    = sample[15:8];
        crc_ctl.init = slot_last;
      end
      S_CRC: begin
        ram_raddr    = ADDR_W'(cnt);
        crc_ctl.step = (cnt != '0);
      end
      S_CLO: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(DATA_BYTES);
        ram_wdata = crc[7:0];
      end
      S_CHI: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(DATA_BYTES + 1);
        ram_wdata = crc[15:8];
      end
      default: ram_raddr = '0;
    endcase
  end

  // Control state: sequencer, slot count, read pointer, valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
      ptr   <= '0;
      vld   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (state == S_WHI) begin
        slot <= slot_last ? '0 : slot + SLOT_W'(1);
        cnt  <= '0;
      end
      if (state == S_CRC) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (accept) begin
        case (op_t'(in_ch.op))
          OP_COMMAND: begin
            if (in_ch.command_byte <= CMD_LAST_SAMPLE) begin
              ptr <= {in_ch.command_byte[6:0], 1'b0};
            end else if (in_ch.command_byte == CMD_CRC_SLOT) begin
              ptr <= CRC_PTR;
            end else begin
              ptr <= BAD_POINTER;
            end
          end
          OP_READ:    ptr <= ptr + 8'd1;
          default:    ptr <= ptr;
        endcase
      end
    end
  end

  // Valid bit of the byte being read, aligned with the RAM output.
  always_ff @(posedge clk) begin
    rd_vld <= vld[ram_raddr];
  end

  // Input latch and result assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample   <= in_ch.sample_value;
      res_byte <= 8'h00;
      res_oor  <= (op_t'(in_ch.op) == OP_READ) && !ptr_in_range;
      res_done <= 1'b0;
      res_crc  <= 16'h0000;
    end
    if (state == S_RDWAIT) begin
      res_byte <= rd_byte;
    end
    if (state == S_CHI) begin
      res_done <= 1'b1;
      res_crc  <= crc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.read_byte    <= res_byte;
      out_ch.out_of_range <= res_oor;
      out_ch.frame_done   <= res_done;
      out_ch.frame_crc    <= res_crc;
    end
  end

  sfcr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  sfcr_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (rd_byte),
    .crc  (crc)
  );

  // A completed frame never also reports a read.
  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.frame_done |-> !out_ch.out_of_range && out_ch.read_byte == 8'h00)
    else $error("frame result carries read data");

  // The slot count stays inside the frame.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(SAMPLES_PER_FRAME - 1))
    else $error("sample slot beyond frame");

  // The store is written only by the sample and CRC write steps.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_WLO || state == S_WHI || state == S_CLO || state == S_CHI)
    else $error("store written outside a write step");

  // A CRC pass always ends with the two CRC byte writes.
  a_crc_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_CRC && cnt == CNT_W'(DATA_BYTES) |=> state == S_CLO ##1 state == S_CHI)
    else $error("CRC pass did not write back");

endmodule

`default_nettype wire

>>> tb/sv/frame_reader_checker.sv
// Checker for the sample frame reader: predicts every result word and compares it.
`default_nettype none

module frame_reader_checker #(
  parameter int SAMPLES_PER_FRAME = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sfcr_in_if          in_mon,
  sfcr_out_if         out_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import sfcr_pkg::*;

  localparam int DATA_BYTES  = 2 * SAMPLES_PER_FRAME;
  localparam int STORE_BYTES = DATA_BYTES + 2;

  // One result word as the block should deliver it.
  typedef struct packed {
    logic [7:0]  read_byte;
    logic        out_of_range;
    logic        frame_done;
    logic [15:0] frame_crc;
  } reply_t;

  // Shadow copy of the block's state.
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned next_slot;
  logic [7:0]  read_ptr;
  reply_t      awaited_replies [$];

  initial mismatches = 0;

  // CRC16 over the sample bytes of the shadow store, one table lookup per byte.
  function automatic logic [15:0] frame_crc16();
    logic [15:0] crc;
    logic [7:0]  idx;
    crc = CRC_INIT;
    for (int k = 0; k < DATA_BYTES; k++) begin
      idx = crc[15:8] ^ shadow_store[k];
      crc = {crc[7:0], 8'h00} ^ CRC_LUT[idx];
    end
    return crc;
  endfunction

  // Applies one accepted input word to the shadow state and queues its result.
  task automatic predict_reply(input op_t op, input logic [15:0] sample,
                               input logic [7:0] cmd);
    reply_t      r;
    int          pos;
    logic [15:0] crc;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        pos = (next_slot % SAMPLES_PER_FRAME) * 2;
        shadow_store[pos]     = sample[7:0];
        shadow_store[pos + 1] = sample[15:8];
        next_slot++;
        // The last sample of a frame closes it with the CRC.
        if (next_slot >= SAMPLES_PER_FRAME) begin
          crc = frame_crc16();
          shadow_store[DATA_BYTES]     = crc[7:0];
          shadow_store[DATA_BYTES + 1] = crc[15:8];
          next_slot   = 0;
          r.frame_done = 1'b1;
          r.frame_crc  = crc;
        end
      end
      OP_COMMAND: begin
        if (cmd <= CMD_LAST_SAMPLE)
          read_ptr = cmd << 1;
        else if (cmd == CMD_CRC_SLOT)
          read_ptr = CRC_PTR;
        else
          read_ptr = BAD_POINTER;
      end
      OP_READ: begin
        if (read_ptr < STORE_BYTES)
          r.read_byte = shadow_store[read_ptr];
        else
          r.out_of_range = 1'b1;
        read_ptr = read_ptr + 8'd1;
      end
      default: begin
      end
    endcase
    awaited_replies.push_back(r);
  endtask

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Watch both channels; inputs are predicted before results are compared.
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      next_slot = 0;
      read_ptr  = 8'h00;
      awaited_replies.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_reply(op_t'(in_mon.op), in_mon.sample_value, in_mon.command_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result word with nothing outstanding",
                          32'({out_mon.read_byte, out_mon.out_of_range, out_mon.frame_done,
                               out_mon.frame_crc}), 0);
        end else begin
          want = awaited_replies.pop_front();
          if (out_mon.read_byte !== want.read_byte)
            report_mismatch("read_byte", 32'(out_mon.read_byte), 32'(want.read_byte));
          if (out_mon.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", 32'(out_mon.out_of_range),
                            32'(want.out_of_range));
          if (out_mon.frame_done !== want.frame_done)
            report_mismatch("frame_done", 32'(out_mon.frame_done), 32'(want.frame_done));
          if (out_mon.frame_crc !== want.frame_crc)
            report_mismatch("frame_crc", 32'(out_mon.frame_crc), 32'(want.frame_crc));
        end
      end
    end
    outstanding = awaited_replies.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench top: clock, reset, word stimulus and final verdict for the frame reader.
`default_nettype none

module tb_top;
  import sfcr_pkg::*;

  localparam int FRAME_SAMPLES  = 4;
  localparam int RANDOM_WORDS   = 900;
  localparam int HOLD_OFF_CYCLS = 300;

  logic        clk;
  logic        rst;
  logic        hold_off_req;
  int          calm_left [2];
  int unsigned words_sent;
  int unsigned mismatches;
  int unsigned outstanding;

  sfcr_in_if  in_ch ();
  sfcr_out_if out_ch ();

  sample_frame_crc_register_reader #(
    .SAMPLES_PER_FRAME(FRAME_SAMPLES)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frame_reader_checker #(
    .SAMPLES_PER_FRAME(FRAME_SAMPLES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("** sample_frame_crc_register_reader: FAILED **");
    $finish;
  end

  // Wait before the next word on one side: mostly random, with calm stretches of none.
  function automatic int pick_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Offers one word at a falling edge and returns at the falling edge after it is taken.
  task automatic send_word(input op_t op, input logic [15:0] sample, input logic [7:0] cmd);
    int gap;
    gap = pick_wait(0);
    if (gap > 0) begin
      in_ch.valid        = 1'b0;
      in_ch.op           = 2'($urandom_range(0, 3));
      in_ch.sample_value = 16'($urandom);
      in_ch.command_byte = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = op;
    in_ch.sample_value = sample;
    in_ch.command_byte = cmd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Directed words: extremes, every operation and the corner cases.
  task automatic run_directed();
    // Read of the cleared store, then the cleared CRC bytes and the end of the store.
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_COMMAND, 16'hFFFF, CMD_CRC_SLOT);
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    // A full frame with extreme sample values and ignored command bytes.
    send_word(OP_SAMPLE, 16'hFFFF, 8'hFF);
    send_word(OP_SAMPLE, 16'h0000, 8'h00);
    send_word(OP_SAMPLE, 16'h8001, 8'h09);
    send_word(OP_SAMPLE, 16'h1234, 8'($urandom));
    // Read back the first and last sample slots and the CRC.
    send_word(OP_COMMAND, 16'h0000, 8'h00);
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_COMMAND, 16'($urandom), CMD_LAST_SAMPLE);
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_COMMAND, 16'($urandom), CMD_CRC_SLOT);
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    // Invalid pointer: the read fails and the pointer wraps to the first byte.
    send_word(OP_COMMAND, 16'($urandom), 8'hFF);
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_READ, 16'($urandom), 8'($urandom));
    send_word(OP_COMMAND, 16'($urandom), 8'd4);
    send_word(OP_COMMAND, 16'($urandom), 8'd10);
    // Unused operation, then a partial frame over the old bytes.
    send_word(OP_NONE, 16'hFFFF, 8'hFF);
    send_word(OP_SAMPLE, 16'hABCD, 8'($urandom));
    send_word(OP_COMMAND, 16'($urandom), 8'h00);
    send_word(OP_READ, 16'($urandom), 8'($urandom));
  endtask

  // Random phase: mostly frames and pointer-then-read bursts, some noise.
  task automatic run_random();
    int          kind;
    int          count;
    int unsigned stop_at;
    logic [7:0]  cmd;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // Full frame now and then cut short.
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : FRAME_SAMPLES;
        repeat (count) send_word(OP_SAMPLE, 16'($urandom), 8'($urandom));
      end else if (kind < 80) begin
        case ($urandom_range(0, 6))
          0, 1, 2: cmd = 8'($urandom_range(0, 3));
          3, 4:    cmd = CMD_CRC_SLOT;
          default: cmd = 8'($urandom);
        endcase
        send_word(OP_COMMAND, 16'($urandom), cmd);
        count = $urandom_range(1, 12);
        repeat (count) send_word(OP_READ, 16'($urandom), 8'($urandom));
      end else if (kind < 92) begin
        send_word(OP_READ, 16'($urandom), 8'($urandom));
      end else begin
        send_word(op_t'(2'($urandom_range(0, 3))), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Result side: random ready gaps, and one long hold-off on request.
  initial begin : result_sink
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = pick_wait(1);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLS;
      end
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    rst                = 1'b1;
    hold_off_req       = 1'b0;
    calm_left[0]       = 0;
    calm_left[1]       = 0;
    words_sent         = 0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_NONE;
    in_ch.sample_value = 16'h0000;
    in_ch.command_byte = 8'h00;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    hold_off_req = 1'b1;
    run_random();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("** sample_frame_crc_register_reader: PASSED **");
    else
      $display("** sample_frame_crc_register_reader: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
